// ===== rtl/core/int8_sum_reduce_requantize_assert.svh =====
// Assertion macros shared by the int8 sum/requantize RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef INT8_SUM_REDUCE_REQUANTIZE_ASSERT_SVH
`define INT8_SUM_REDUCE_REQUANTIZE_ASSERT_SVH

// same-cycle implication
`define ISRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/isrq_pkg.sv =====
// Shared types and constants for the int8 sum/requantize block.
// No dependencies; imported by every module of the block.
package isrq_pkg;

  parameter int ACC_WIDTH_DEF = 32;
  parameter int WORD_W        = 32;
  parameter int CFG_IDX_W     = 2;
  parameter int CFG_DATA_W    = 32;
  parameter int OUT_MAX       = 127;
  parameter int OUT_MIN       = -128;

  parameter logic [30:0] MULT_RESET = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_ZP  = 2'd0,
    REG_OUT_ZP = 2'd1,
    REG_MULT   = 2'd2,
    REG_SHIFT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [7:0] in_zp;
    logic signed [7:0] out_zp;
    logic [30:0]       mult;
    logic signed [5:0] shift;
  } cfg_t;

  // handshake and occupancy of the requantize pipeline
  typedef struct packed {
    logic take;
    logic scaled_valid;
    logic prod_valid;
  } pipe_status_t;

endpackage

// ===== rtl/core/isrq_cfg_regs.sv =====
// Configuration register file: zero points, multiplier and shift.
// Depends on isrq_pkg.
module isrq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [isrq_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [isrq_pkg::CFG_DATA_W-1:0]  wr_data,
  output isrq_pkg::cfg_t                   cfg
);
  import isrq_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.in_zp  <= '0;
      regs.out_zp <= '0;
      regs.mult   <= MULT_RESET;
      regs.shift  <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        REG_IN_ZP:  regs.in_zp  <= wr_data[7:0];
        REG_OUT_ZP: regs.out_zp <= wr_data[7:0];
        REG_MULT:   regs.mult   <= wr_data[30:0];
        REG_SHIFT:  regs.shift  <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== rtl/core/isrq_accum.sv =====
// Input stage: accumulates (sample - in_zp) and hands the 32-bit group word on.
// Depends on isrq_pkg.
module isrq_accum #(
  parameter int ACC_WIDTH = isrq_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [7:0]            in_zp,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [7:0]            sample,
  input  logic                         group_end,
  output logic                         grp_valid,
  output logic [isrq_pkg::WORD_W-1:0]  grp_word,
  input  logic                         grp_take
);
  import isrq_pkg::*;

  localparam int EXT_W = ACC_WIDTH + WORD_W;

  logic [ACC_WIDTH-1:0] running_sum;
  logic [ACC_WIDTH-1:0] running_sum_next;
  logic signed [8:0]    delta;
  logic [EXT_W-1:0]     sum_ext;
  logic                 accept;
  logic                 grp_free;

  assign delta            = 9'(sample) - 9'(in_zp);
  assign running_sum_next = running_sum + ACC_WIDTH'(delta);
  // narrower accumulators zero-fill up to the word
  assign sum_ext          = {{WORD_W{1'b0}}, running_sum_next};

  assign grp_free = !grp_valid || grp_take;
  assign in_stall = !grp_free;
  assign accept   = in_valid && grp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (accept) begin
      running_sum <= group_end ? '0 : running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (grp_free) begin
      grp_valid <= accept && group_end;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && group_end) begin
      grp_word <= sum_ext[WORD_W-1:0];
    end
  end

endmodule

// ===== rtl/core/isrq_requant.sv =====
// Requantize pipeline: rescale by shift, high-word multiply, round, offset, clip.
// Depends on isrq_pkg.
module isrq_requant (
  input  logic                         clk,
  input  logic                         rst,
  input  isrq_pkg::cfg_t               cfg,
  input  logic                         grp_valid,
  input  logic [isrq_pkg::WORD_W-1:0]  grp_word,
  output isrq_pkg::pipe_status_t       status,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [7:0]            out_value
);
  import isrq_pkg::*;

  logic signed [31:0] word_s;
  logic signed [31:0] scaled_word;
  logic signed [31:0] scaled;
  logic               scaled_valid;
  logic signed [31:0] mult_s;
  logic signed [63:0] prod_full;
  logic signed [32:0] prod_hi;
  logic               prod_valid;
  logic signed [32:0] hi_round;
  logic signed [32:0] biased;
  logic signed [7:0]  clipped;
  logic               out_ready;
  logic               prod_ready;
  logic               scaled_ready;

  assign out_ready    = !out_valid || !out_stall;
  assign prod_ready   = !prod_valid || out_ready;
  assign scaled_ready = !scaled_valid || prod_ready;

  // rescale: right by -shift-1, or left by shift+1 (all bits lost at 32)
  assign word_s = grp_word;
  always_comb begin
    if (cfg.shift[5]) begin
      scaled_word = word_s >>> (~cfg.shift[4:0]);
    end else if (cfg.shift[4:0] == 5'd31) begin
      scaled_word = '0;
    end else begin
      scaled_word = word_s << (cfg.shift[4:0] + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid <= 1'b0;
    end else if (scaled_ready) begin
      scaled_valid <= grp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scaled_ready && grp_valid) begin
      scaled <= scaled_word;
    end
  end

  // keep bit 31 of the product: it carries the rounding half
  assign mult_s    = {1'b0, cfg.mult};
  assign prod_full = scaled * mult_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= scaled_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && scaled_valid) begin
      prod_hi <= prod_full[63:31];
    end
  end

  assign hi_round = {prod_hi[32], prod_hi[32:1]} + {32'd0, prod_hi[0]};
  assign biased   = hi_round + 33'(cfg.out_zp);

  always_comb begin
    if (biased > OUT_MAX) begin
      clipped = 8'(OUT_MAX);
    end else if (biased < OUT_MIN) begin
      clipped = 8'(OUT_MIN);
    end else begin
      clipped = biased[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      out_value <= clipped;
    end
  end

  assign status.take         = scaled_ready;
  assign status.scaled_valid = scaled_valid;
  assign status.prod_valid   = prod_valid;

endmodule

// ===== rtl/core/int8_sum_reduce_requantize.sv =====
// Top level of the grouped int8 sum with requantization.
// Depends on isrq_pkg, isrq_cfg_regs, isrq_accum, isrq_requant and the assert header.
//
// Usage:
//   Sample channel: sample, group_end with sample_valid/sample_stall. Every
//   transaction adds (sample - in_zero_point) to the accumulator; a
//   transaction with group_end set closes the group and clears it.
//   Result channel: reduced_value with result_valid/result_stall, one
//   transaction per closed group, in group order.
//   Config channel: cfg_index/cfg_data with cfg_valid/cfg_ready; cfg_ready is
//   always high. Index 0 in_zero_point, 1 out_zero_point, 2 scale_multiplier,
//   3 scale_shift. Write only while no group result is in flight.
// Timing:
//   One sample per cycle while sample_stall is low. The group register loads at the edge
//   that takes a group's last sample; the rescale, product (one 32x32 multiplier)
//   and output registers follow in that order, and the result is valid from the output register.
// Reset: rst clears the accumulator, all stage valids and the config registers
//   to their defaults (multiplier 2^30, everything else 0).
// Stall: a stalled result holds; the stages behind it keep filling and
//   sample_stall rises only once all four group slots are full.
`include "int8_sum_reduce_requantize_assert.svh"

module int8_sum_reduce_requantize #(
  parameter int ACC_WIDTH = isrq_pkg::ACC_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [isrq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isrq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             sample_valid,
  output logic                             sample_stall,
  input  logic signed [7:0]                sample,
  input  logic                             group_end,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic signed [7:0]                reduced_value
);
  import isrq_pkg::*;

  cfg_t                cfg;
  pipe_status_t        status;
  logic                grp_valid;
  logic [WORD_W-1:0]   grp_word;

  assign cfg_ready = 1'b1;

  isrq_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  isrq_accum #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_zp     (cfg.in_zp),
    .in_valid  (sample_valid),
    .in_stall  (sample_stall),
    .sample    (sample),
    .group_end (group_end),
    .grp_valid (grp_valid),
    .grp_word  (grp_word),
    .grp_take  (status.take)
  );

  isrq_requant u_requant (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .grp_valid (grp_valid),
    .grp_word  (grp_word),
    .status    (status),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_value (reduced_value)
  );

  `ISRQ_ASSERT_NEXT(a_group_end_loads, sample_valid && !sample_stall && group_end, grp_valid, "closed group did not reach the group register")
  `ISRQ_ASSERT_NOW(a_stall_only_full, sample_stall, grp_valid && status.scaled_valid && status.prod_valid && result_valid && result_stall, "sample stalled with a free group slot")
  `ISRQ_ASSERT_NOW(a_result_from_product, $rose(result_valid), $past(status.prod_valid), "result appeared without a product")

endmodule

// ===== test/tb_int8_sum_reduce_requantize.sv =====
// Testbench for int8_sum_reduce_requantize: grouped int8 sums, requantized and saturated.
// Depends on isrq_pkg and the block's RTL; a scoreboard class predicts every group result.
`timescale 1ns / 1ps

module tb_int8_sum_reduce_requantize;
  import isrq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 152;

  class reduce_scoreboard;
    logic signed [7:0]          in_zp;
    logic signed [7:0]          out_zp;
    logic [30:0]                mult;
    logic signed [5:0]          shift;
    logic [ACC_WIDTH_DEF-1:0]   running_sum;
    logic signed [7:0]          expected_q[$];
    int                         errors;
    int                         checked;

    function new();
      in_zp       = '0;
      out_zp      = '0;
      mult        = MULT_RESET;
      shift       = '0;
      running_sum = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IN_ZP:  in_zp  = data[7:0];
        REG_OUT_ZP: out_zp = data[7:0];
        REG_MULT:   mult   = data[30:0];
        REG_SHIFT:  shift  = data[5:0];
        default: ;
      endcase
    endfunction

    // rescale by the shift, rounding high-word product, zero point, clip
    function logic signed [7:0] requantize(logic [31:0] acc);
      longint            word;
      longint            prod;
      longint            hi;
      longint            r;
      logic [31:0]       shifted;
      int                n;
      word = longint'($signed(acc));
      if (shift < 0) begin
        n = -int'(shift) - 1;
        word = word >>> n;
      end else begin
        n = int'(shift) + 1;
        if (n >= 32) begin
          word = 0;
        end else begin
          shifted = acc << n;
          word = longint'($signed(shifted));
        end
      end
      prod = word * longint'(mult);
      hi = (prod + (longint'(1) <<< 31)) >>> 32;
      r = hi + longint'(out_zp);
      if (r > OUT_MAX) r = OUT_MAX;
      else if (r < OUT_MIN) r = OUT_MIN;
      return r[7:0];
    endfunction

    function void note_sample(logic signed [7:0] s, logic last);
      int diff;
      diff = int'(s) - int'(in_zp);
      running_sum = running_sum + diff;
      if (last) begin
        expected_q.push_back(requantize(running_sum[31:0]));
        running_sum = '0;
      end
    endfunction

    function void check_result(logic signed [7:0] got);
      logic signed [7:0] want;
      if (expected_q.size() == 0) begin
        $error("reduced_value: unexpected transaction, actual %0d", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $error("reduced_value mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_IN_ZP;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  logic signed [7:0]      sample = '0;
  logic                   group_end = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic signed [7:0]      reduced_value;

  reduce_scoreboard sb = new();
  bit  steady = 1'b0;
  int  idle_cycles = 0;
  int  samples_sent = 0;
  int  groups_sent = 0;
  int  settings_used = 1;

  int8_sum_reduce_requantize dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .group_end    (group_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .reduced_value(reduced_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check on each transaction, then pick the next stall
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(reduced_value);
    result_stall <= steady ? 1'b0 : ($urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_sample(logic signed [7:0] s, logic last);
    if (!steady) begin
      while ($urandom_range(99) < 37) begin
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_valid <= 1'b1;
    sample       <= s;
    group_end    <= last;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    sb.note_sample(s, last);
    samples_sent++;
    if (last) groups_sent++;
  endtask

  // fill: 0 random, 1 all max, 2 all min, 3 extremes mixed
  task automatic send_group(int len, int fill);
    logic signed [7:0] s;
    for (int i = 0; i < len; i++) begin
      case (fill)
        1:       s = 8'sd127;
        2:       s = -8'sd128;
        3:       s = $urandom_range(1) ? 8'sd127 : -8'sd128;
        default: s = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'sd127 : -8'sd128)
                                               : 8'($urandom_range(255));
      endcase
      push_sample(s, i == len - 1);
    end
  endtask

  // hold until every group result is out and the pipeline has settled
  task automatic wait_quiet();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [7:0] izp, logic [7:0] ozp, logic [30:0] m,
                              logic [5:0] sh);
    logic [CFG_DATA_W-1:0] junk;
    wait_quiet();
    // upper bits carry noise that the block must drop
    junk = $urandom;
    write_reg(REG_IN_ZP,  {junk[31:8], izp});
    junk = $urandom;
    write_reg(REG_OUT_ZP, {junk[31:8], ozp});
    junk = $urandom;
    write_reg(REG_MULT,   {junk[31], m});
    junk = $urandom;
    write_reg(REG_SHIFT,  {junk[31:6], sh});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_phase();
    logic [7:0]  izp;
    logic [7:0]  ozp;
    logic [30:0] m;
    logic [5:0]  sh;
    int          pick;
    int          len;
    int          count;
    izp = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'h7f : 8'h80) : 8'($urandom);
    ozp = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'h7f : 8'h80) : 8'($urandom);
    pick = $urandom_range(7);
    case (pick)
      0:       m = '0;
      1:       m = '1;
      2:       m = 31'($urandom_range(65535));
      default: m = 31'($urandom);
    endcase
    // favor right shifts so results do not always clip
    pick = $urandom_range(3);
    case (pick)
      0:       sh = 6'($urandom);
      1:       sh = $urandom_range(1) ? 6'sd31 : -6'sd32;
      default: sh = 6'(-int'($urandom_range(24, 1)));
    endcase
    program_regs(izp, ozp, m, sh);
    count = 0;
    while (count < PHASE_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(6, 1);
      else if (pick < 93) len = $urandom_range(40, 7);
      else len = $urandom_range(300, 41);
      // trim the last group so the phase sends its exact share
      if (len > PHASE_ITEMS - count) len = PHASE_ITEMS - count;
      pick = $urandom_range(99);
      send_group(len, (pick < 85) ? 0 : $urandom_range(3, 1));
      count += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single-sample groups and runs at both extremes
    send_group(1, 1);
    send_group(1, 2);
    push_sample(8'sd0, 1'b1);
    send_group(4, 1);
    send_group(5, 2);
    push_sample(8'sd1, 1'b1);

    // widest zero points and multiplier, largest in-range left shift
    program_regs(8'h80, 8'h7f, '1, 6'sd30);
    send_group(1, 1);
    send_group(2, 2);
    push_sample(-8'sd1, 1'b1);

    // zero multiplier and the deepest right shift
    program_regs(8'h7f, 8'h80, '0, -6'sd32);
    send_group(1, 2);
    send_group(1, 1);

    // shift of 31: every bit leaves the word
    program_regs(8'h05, 8'hfd, '1, 6'sd31);
    push_sample(8'sd100, 1'b1);
    push_sample(-8'sd50, 1'b0);
    push_sample(8'sd20, 1'b1);

    // left shift that wraps past bit 31
    program_regs(8'h00, 8'h00, 31'h0000_0100, 6'sd24);
    send_group(3, 1);
    send_group(3, 2);
    push_sample(8'sd64, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      steady = (p == 5);
      random_phase();
    end
    steady = 1'b0;

    wait_quiet();
    if (sb.expected_q.size() != 0) begin
      $error("reduced_value: %0d expected transactions never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("Sent %0d samples in %0d groups across %0d register settings;",
             samples_sent, groups_sent, settings_used);
    $display("checked %0d requantized results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
